[hw/rtl/hds_pkg.sv]
// hds_pkg: shared constants for the heat diffusion stencil.
// Reset values, register map and default widths; no dependencies.
package hds_pkg;

    localparam int MAX_GRID_DEF    = 256;
    localparam int VALUE_WIDTH_DEF = 16;

    localparam int PHI_W       = 8;
    localparam int GRID_SIZE_W = 9;

    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    localparam logic [PHI_W-1:0]       PHI_RESET       = PHI_W'(61);
    localparam logic [GRID_SIZE_W-1:0] GRID_SIZE_RESET = GRID_SIZE_W'(256);

    // register select is paddr[2]
    localparam logic REG_PHI       = 1'b0;
    localparam logic REG_GRID_SIZE = 1'b1;

endpackage

[hw/rtl/hds_cell_if.sv]
// hds_cell_if: valid/ready channel carrying one grid cell word.
// Depends on hds_pkg for the default value width.
interface hds_cell_if
    import hds_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] cell_value;
    logic                          pad;

    modport source (output valid, output cell_value, output pad, input ready);
    modport sink   (input valid, input cell_value, input pad, output ready);
endinterface

[hw/rtl/hds_result_if.sv]
// hds_result_if: valid/ready channel carrying one updated cell word.
// Depends on hds_pkg for the default value width.
interface hds_result_if
    import hds_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] new_value;
    logic                          last;

    modport source (output valid, output new_value, output last, input ready);
    modport sink   (input valid, input new_value, input last, output ready);
endinterface

[hw/rtl/hds_ram.sv]
// hds_ram: generic single-write, single-read RAM with registered read data.
// No dependencies; read data holds while re is low.
module hds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[hw/rtl/heat_diffusion_stencil.sv]
// heat_diffusion_stencil: five-point explicit heat diffusion pass over a square grid.
// Depends on hds_pkg, hds_cell_if, hds_result_if and hds_ram (line store).
//
//   channel   dir  word                          handshake
//   cells     in   cell_value[VW], pad           valid/ready
//   results   out  new_value[VW], last           valid/ready
//   apb       cfg  phi @0x0, grid_size @0x4      psel/penable, pready tied high
//
// One cell word accepted per cycle while cells.ready is high. The result for a cell
// leaves N+1 words after it, then four pipeline stages later: line store read,
// window/laplacian, multiply by phi, round and saturate. Both line rows share one RAM
// entry per column, read at accept and written back one stage later, with forwarding.
// rst_n clears control only; the line store needs no clearing pass.
// Stalls back up stage by stage; cells.ready drops only when all stages are full.
module heat_diffusion_stencil
    import hds_pkg::*;
#(
    parameter int MAX_GRID    = MAX_GRID_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    hds_cell_if.sink          cells,
    hds_result_if.source      results,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);
    localparam int AW     = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
    localparam int SW_RAW = $clog2(MAX_GRID + 2);
    localparam int SW     = (SW_RAW > GRID_SIZE_W) ? SW_RAW : GRID_SIZE_W;
    localparam int VW     = VALUE_WIDTH;
    localparam int LW     = VW + 3;
    localparam int PW     = LW + 9;
    localparam int XW     = VW + 12;
    localparam int QW     = XW - 8;

    localparam logic [SW-1:0] MAX_N = SW'(MAX_GRID);
    localparam logic [SW-1:0] TWO_N = SW'(2);

    localparam logic signed [XW-1:0] HALF = XW'(128);
    localparam logic signed [QW-1:0] Q_HI = {{(QW-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic signed [QW-1:0] Q_LO = {{(QW-VW+1){1'b1}}, {(VW-1){1'b0}}};

    typedef struct packed {
        logic n_zero;
        logic s_zero;
        logic w_zero;
        logic e_zero;
        logic last;
    } edge_flags_t;

    // config
    logic [PHI_W-1:0]       phi_reg;
    logic [GRID_SIZE_W-1:0] grid_size_reg;
    logic                   cfg_wr;

    // position
    logic [AW-1:0] col_reg;
    logic [SW-1:0] row_reg;

    // stage 1: line store read
    logic                 s1_v_reg;
    logic                 s1_emit_reg;
    edge_flags_t          s1_flags_reg;
    logic [AW-1:0]        s1_col_reg;
    logic signed [VW-1:0] s1_val_reg;
    logic                 fwd_reg;
    logic [2*VW-1:0]      fwd_data_reg;

    // window: newest column in full, previous column middle only
    logic signed [VW-1:0] win_top_reg;
    logic signed [VW-1:0] win_mid_reg;
    logic signed [VW-1:0] win_bot_reg;
    logic signed [VW-1:0] win_prev_mid_reg;

    // stage 2: laplacian
    logic                 s2_v_reg;
    logic signed [VW-1:0] s2_c_reg;
    logic signed [LW-1:0] s2_lap_reg;
    logic                 s2_last_reg;

    // stage 3: scaled sum
    logic                 s3_v_reg;
    logic signed [XW-1:0] s3_x_reg;
    logic                 s3_last_reg;

    // output register
    logic                 out_v_reg;
    logic signed [VW-1:0] out_val_reg;
    logic                 out_last_reg;

    logic rdy_out, rdy3, rdy2, rdy1, in_acc, s1_adv;

    logic [SW-1:0] gs_ext, n_eff, n_m1, col_ext, col_c, row_c, tr, tc;
    logic [SW-1:0] col_inc, row_inc, col_next, row_next;
    logic          warm;
    edge_flags_t   flags;
    logic signed [VW-1:0] v_in;

    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [2*VW-1:0] ram_wdata, ram_rdata, s1_rd;
    logic signed [VW-1:0] rd_above, rd_center;

    logic signed [VW-1:0] nv, sv, ev, wv;
    logic signed [LW-1:0] lap;
    logic signed [PW-1:0] prod;
    logic signed [XW-1:0] x_next;
    logic signed [QW-1:0] q;
    logic signed [VW-1:0] q_sat;

    // APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            REG_PHI:       prdata = APB_DW'(phi_reg);
            REG_GRID_SIZE: prdata = APB_DW'(grid_size_reg);
            default:       prdata = '0;
        endcase
    end

    // handshake chain
    assign rdy_out     = !out_v_reg || results.ready;
    assign rdy3        = !s3_v_reg || rdy_out;
    assign rdy2        = !s2_v_reg || rdy3;
    assign rdy1        = !s1_v_reg || rdy2;
    assign cells.ready = rdy1;
    assign in_acc      = cells.valid && rdy1;
    assign s1_adv      = s1_v_reg && rdy2;

    // position decode
    always_comb
    begin
        gs_ext  = SW'(grid_size_reg);
        n_eff   = (gs_ext < TWO_N) ? TWO_N : ((gs_ext > MAX_N) ? MAX_N : gs_ext);
        n_m1    = n_eff - SW'(1);
        col_ext = SW'(col_reg);
        col_c   = (col_ext >= n_eff) ? n_m1 : col_ext;
        row_c   = (row_reg > n_eff + SW'(1)) ? n_eff + SW'(1) : row_reg;
        warm    = (row_c == '0) || (row_c == SW'(1) && col_c == '0);
        tr      = (col_c == '0) ? row_c - SW'(2) : row_c - SW'(1);
        tc      = (col_c == '0) ? n_m1 : col_c - SW'(1);
        flags.n_zero = (tr == '0);
        flags.s_zero = (tr >= n_m1);
        flags.w_zero = (tc == '0);
        flags.e_zero = (tc >= n_m1);
        flags.last   = flags.s_zero && flags.e_zero;
        col_inc = col_c + SW'(1);
        row_inc = row_c + SW'(1);
        if (!warm && flags.last)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (col_inc >= n_eff)
        begin
            col_next = '0;
            row_next = row_inc;
        end
        else
        begin
            col_next = col_inc;
            row_next = row_c;
        end
        v_in = cells.pad ? '0 : cells.cell_value;
    end

    // line store: {row r-2, row r-1} per column
    assign ram_re    = in_acc;
    assign ram_raddr = col_c[AW-1:0];
    assign ram_we    = s1_adv;
    assign ram_waddr = s1_col_reg;
    assign s1_rd     = fwd_reg ? fwd_data_reg : ram_rdata;
    assign rd_above  = s1_rd[2*VW-1:VW];
    assign rd_center = s1_rd[VW-1:0];
    assign ram_wdata = {rd_center, s1_val_reg};

    hds_ram #(
        .WIDTH (2 * VW),
        .DEPTH (MAX_GRID)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // laplacian on the shifted window
    always_comb
    begin
        nv  = s1_flags_reg.n_zero ? '0 : win_top_reg;
        sv  = s1_flags_reg.s_zero ? '0 : win_bot_reg;
        wv  = s1_flags_reg.w_zero ? '0 : win_prev_mid_reg;
        ev  = s1_flags_reg.e_zero ? '0 : rd_center;
        lap = LW'(nv) + LW'(sv) + LW'(ev) + LW'(wv) - (LW'(win_mid_reg) <<< 2);
    end

    assign prod   = PW'(s2_lap_reg) * PW'($signed({1'b0, phi_reg}));
    assign x_next = XW'(prod) + (XW'(s2_c_reg) <<< 8) + HALF;

    always_comb
    begin
        q = s3_x_reg[XW-1:8];
        if (q > Q_HI)
        begin
            q_sat = Q_HI[VW-1:0];
        end
        else if (q < Q_LO)
        begin
            q_sat = Q_LO[VW-1:0];
        end
        else
        begin
            q_sat = q[VW-1:0];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phi_reg       <= PHI_RESET;
            grid_size_reg <= GRID_SIZE_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            s1_v_reg      <= 1'b0;
            fwd_reg       <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            out_v_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr && paddr[2] == REG_PHI)
            begin
                phi_reg <= pwdata[PHI_W-1:0];
            end
            if (cfg_wr && paddr[2] == REG_GRID_SIZE)
            begin
                grid_size_reg <= pwdata[GRID_SIZE_W-1:0];
                col_reg       <= '0;
                row_reg       <= '0;
            end
            else if (in_acc)
            begin
                col_reg <= col_next[AW-1:0];
                row_reg <= row_next;
            end
            if (rdy1)
            begin
                s1_v_reg <= cells.valid;
            end
            if (in_acc)
            begin
                fwd_reg <= s1_adv && (s1_col_reg == ram_raddr);
            end
            if (rdy2)
            begin
                s2_v_reg <= s1_v_reg && s1_emit_reg;
            end
            if (rdy3)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (rdy_out)
            begin
                out_v_reg <= s3_v_reg;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_emit_reg  <= !warm;
            s1_flags_reg <= flags;
            s1_col_reg   <= col_c[AW-1:0];
            s1_val_reg   <= v_in;
            fwd_data_reg <= ram_wdata;
        end
        if (s1_adv)
        begin
            win_prev_mid_reg <= win_mid_reg;
            win_top_reg      <= rd_above;
            win_mid_reg      <= rd_center;
            win_bot_reg      <= s1_val_reg;
        end
        if (rdy2)
        begin
            s2_c_reg    <= win_mid_reg;
            s2_lap_reg  <= lap;
            s2_last_reg <= s1_flags_reg.last;
        end
        if (rdy3)
        begin
            s3_x_reg    <= x_next;
            s3_last_reg <= s2_last_reg;
        end
        if (rdy_out)
        begin
            out_val_reg  <= q_sat;
            out_last_reg <= s3_last_reg;
        end
    end

    assign results.valid     = out_v_reg;
    assign results.new_value = out_val_reg;
    assign results.last      = out_last_reg;

    a_fwd_on_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re && ram_waddr == ram_raddr) |=> fwd_reg)
        else $error("line store collision not forwarded");

    a_pass_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !warm && flags.last) |=> (row_reg == '0 && col_reg == '0))
        else $error("position not cleared after last cell");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !cells.ready |-> (s1_v_reg && s2_v_reg && s3_v_reg && out_v_reg))
        else $error("input stalled with a free stage");

endmodule

[tb/hds_update_checker.sv]
`timescale 1ns / 1ps
// hds_update_checker: watches the cell, result and APB ports of the heat diffusion stencil,
// predicts every updated cell word and compares it with what the block emits.
// Depends on hds_pkg for the register map, reset values and widths.
module hds_update_checker
    import hds_pkg::*;
#(
    parameter int VW       = VALUE_WIDTH_DEF,
    parameter int MAX_GRID = MAX_GRID_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cell_valid,
    input  logic                 cell_ready,
    input  logic signed [VW-1:0] cell_value,
    input  logic                 cell_pad,
    input  logic                 res_valid,
    input  logic                 res_ready,
    input  logic signed [VW-1:0] new_value,
    input  logic                 res_last,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output int                   mismatch_count,
    output int                   outstanding
);

    typedef logic signed [VW-1:0] cell_t;
    typedef struct packed {
        cell_t top;
        cell_t mid;
        cell_t bot;
    } column_t;
    typedef struct packed {
        cell_t value;
        logic  last;
    } update_t;

    cell_t   above_row  [MAX_GRID];
    cell_t   center_row [MAX_GRID];
    column_t window     [3];
    int      col_pos;
    int      row_pos;
    int      phi_q;
    int      side_reg;
    int      fail_tally;
    update_t expected_updates [$];
    update_t want;

    function automatic cell_t diffuse(cell_t c, cell_t n, cell_t s, cell_t e, cell_t w);
        longint lap;
        longint x;
        longint q;
        longint hi;
        longint lo;
        hi  = (longint'(1) <<< (VW - 1)) - 1;
        lo  = -hi - 1;
        lap = longint'(n) + longint'(s) + longint'(e) + longint'(w) - 4 * longint'(c);
        x   = longint'(c) * 256 + longint'(phi_q) * lap + 128;
        q   = x >>> 8;
        if (q > hi)
            q = hi;
        if (q < lo)
            q = lo;
        return cell_t'(q);
    endfunction

    function automatic void step_stencil(cell_t raw, logic pad);
        int      side;
        int      col;
        int      row;
        int      tr;
        int      tc;
        cell_t   v;
        cell_t   nv;
        cell_t   sv;
        cell_t   ev;
        cell_t   wv;
        column_t fresh;
        logic    last_flag;
        side = side_reg < 2 ? 2 : (side_reg > MAX_GRID ? MAX_GRID : side_reg);
        col  = col_pos;
        row  = row_pos;
        if (col >= side)
            col = side - 1;
        if (row > side + 1)
            row = side + 1;
        v         = pad ? cell_t'(0) : raw;
        fresh.top = above_row[col];
        fresh.mid = center_row[col];
        fresh.bot = v;
        above_row[col]  = center_row[col];
        center_row[col] = v;
        window[0] = window[1];
        window[1] = window[2];
        window[2] = fresh;
        if (row == 0 || (row == 1 && col == 0))
        begin
            col++;
            if (col >= side)
            begin
                col = 0;
                row++;
            end
        end
        else
        begin
            if (col == 0)
            begin
                tr = row - 2;
                tc = side - 1;
            end
            else
            begin
                tr = row - 1;
                tc = col - 1;
            end
            nv = tr == 0 ? cell_t'(0) : window[1].top;
            sv = tr >= side - 1 ? cell_t'(0) : window[1].bot;
            wv = tc == 0 ? cell_t'(0) : window[0].mid;
            ev = tc >= side - 1 ? cell_t'(0) : window[2].mid;
            last_flag = (tr >= side - 1) && (tc >= side - 1);
            expected_updates.push_back('{diffuse(window[1].mid, nv, sv, ev, wv), last_flag});
            if (last_flag)
            begin
                col = 0;
                row = 0;
            end
            else
            begin
                col++;
                if (col >= side)
                begin
                    col = 0;
                    row++;
                end
            end
        end
        col_pos = col;
        row_pos = row;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_GRID; i++)
            begin
                above_row[i]  = '0;
                center_row[i] = '0;
            end
            for (int i = 0; i < 3; i++)
                window[i] = '0;
            col_pos    = 0;
            row_pos    = 0;
            phi_q      = int'(PHI_RESET);
            side_reg   = int'(GRID_SIZE_RESET);
            fail_tally = 0;
            expected_updates.delete();
            mismatch_count <= 0;
            outstanding    <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_PHI)
                    phi_q = int'(pwdata[PHI_W-1:0]);
                else
                begin
                    side_reg = int'(pwdata[GRID_SIZE_W-1:0]);
                    col_pos  = 0;
                    row_pos  = 0;
                end
            end
            if (res_valid && res_ready)
            begin
                if (expected_updates.size() == 0)
                begin
                    fail_tally++;
                    if (fail_tally <= 10)
                        $display("%0t: unexpected word: new_value %0d last %0b",
                                 $realtime, new_value, res_last);
                end
                else
                begin
                    want = expected_updates.pop_front();
                    if (new_value !== want.value || res_last !== want.last)
                    begin
                        fail_tally++;
                        if (fail_tally <= 10)
                            $display("%0t: word mismatch: expected %0d last %0b, got %0d last %0b",
                                     $realtime, want.value, want.last, new_value, res_last);
                    end
                end
            end
            if (cell_valid && cell_ready)
                step_stencil(cell_value, cell_pad);
            mismatch_count <= fail_tally;
            outstanding    <= expected_updates.size();
        end
    end

endmodule

[tb/tb_heat_diffusion_stencil.sv]
`timescale 1ns / 1ps
// tb_heat_diffusion_stencil: drives grid passes, pads and register writes into the stencil.
// Depends on hds_pkg, hds_cell_if, hds_result_if, the block and hds_update_checker.
module tb_heat_diffusion_stencil;
    import hds_pkg::*;

    typedef logic signed [VALUE_WIDTH_DEF-1:0] cell_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    int                mismatch_count;
    int                outstanding;
    logic              steady;
    logic              hold_go;
    logic              hold_done;
    int                hold_left;
    int                cells_sent;

    hds_cell_if   cell_ch ();
    hds_result_if res_ch ();

    always #10 clk = ~clk;

    heat_diffusion_stencil uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cells   (cell_ch),
        .results (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    hds_update_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cell_valid     (cell_ch.valid),
        .cell_ready     (cell_ch.ready),
        .cell_value     (cell_ch.cell_value),
        .cell_pad       (cell_ch.pad),
        .res_valid      (res_ch.valid),
        .res_ready      (res_ch.ready),
        .new_value      (res_ch.new_value),
        .res_last       (res_ch.last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: random backpressure, plus one long hold-off on request
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go)
            begin
                hold_go   = 1'b0;
                hold_left = 500;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= steady || ($urandom_range(99) >= 38);
        end
    end

    function automatic cell_t rand_cell();
        case ($urandom_range(9))
            0: return cell_t'(16'sh7fff);
            1: return cell_t'(16'sh8000);
            2: return cell_t'(0);
            3, 4, 5: return cell_t'(int'($urandom_range(4095)) - 2048);
            default: return cell_t'($urandom);
        endcase
    endfunction

    function automatic int rand_phi();
        case ($urandom_range(6))
            0: return 0;
            1: return 255;
            default: return $urandom_range(255);
        endcase
    endfunction

    task automatic reg_write(logic sel, int value);
        cell_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_word(cell_t v, logic p);
        if (!steady)
            while ($urandom_range(99) < 38)
            begin
                cell_ch.valid <= 1'b0;
                @(posedge clk);
            end
        cell_ch.valid      <= 1'b1;
        cell_ch.cell_value <= v;
        cell_ch.pad        <= p;
        @(posedge clk);
        while (!cell_ch.ready)
            @(posedge clk);
    endtask

    // grid cells then flush pads; noisy adds pads inside the grid and live cells in the flush
    task automatic run_pass(int side, int length, bit noisy);
        for (int i = 0; i < length; i++)
        begin
            if (i < side * side)
            begin
                send_word(rand_cell(), noisy && $urandom_range(99) < 4);
            end
            else
                send_word(rand_cell(), !(noisy && $urandom_range(99) < 25));
            cells_sent++;
        end
    endtask

    initial
    begin
        int side;
        int grid_code;
        int full;
        int passes;
        cell_ch.valid      <= 1'b0;
        cell_ch.cell_value <= '0;
        cell_ch.pad        <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        rst_n   <= 1'b0;
        steady     = 1'b0;
        hold_go    = 1'b0;
        hold_done  = 1'b0;
        hold_left  = 0;
        cells_sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest grid, strongest diffusion, extremes, pad inside grid, live cell in flush
        reg_write(REG_GRID_SIZE, 2);
        reg_write(REG_PHI, 255);
        send_word(16'sh7fff, 1'b0);
        send_word(16'sh8000, 1'b0);
        send_word(16'sh7fff, 1'b1);
        send_word(-16'sd1, 1'b0);
        send_word(16'sd0, 1'b1);
        send_word(16'sd12345, 1'b0);
        send_word(16'sd0, 1'b1);

        // size below range clamps to 2; no diffusion
        reg_write(REG_GRID_SIZE, 0);
        reg_write(REG_PHI, 0);
        send_word(16'sh8000, 1'b0);
        send_word(16'sh7fff, 1'b0);
        send_word(16'sd1, 1'b0);
        send_word(-16'sd1, 1'b0);
        repeat (3) send_word(16'sh5a5a, 1'b1);

        // checkerboard of extremes saturates both ways
        reg_write(REG_GRID_SIZE, 3);
        reg_write(REG_PHI, 128);
        for (int i = 0; i < 9; i++)
            send_word(i % 2 ? 16'sh8000 : 16'sh7fff, 1'b0);
        repeat (4) send_word(16'sh0000, 1'b1);

        cells_sent = 0;
        while (cells_sent < 550)
        begin
            case ($urandom_range(19))
                0: side = $urandom_range(21, 24);
                1, 2, 3, 4, 5: side = $urandom_range(9, 20);
                default: side = $urandom_range(2, 8);
            endcase
            grid_code = side;
            if (side == 2 && $urandom_range(1))
                grid_code = $urandom_range(1);
            reg_write(REG_GRID_SIZE, grid_code);
            if ($urandom_range(9) < 6)
                reg_write(REG_PHI, rand_phi());
            steady = cells_sent >= 250 && cells_sent < 400;
            passes = (side >= 9) ? 1 : $urandom_range(1, 3);
            full   = side * side + side + 1;
            repeat (passes)
            begin
                if ($urandom_range(99) < 8)
                    run_pass(side, $urandom_range(1, full - 1), 1'b1);
                else
                begin
                    if (!hold_done && cells_sent >= 150 && side >= 6)
                    begin
                        hold_go   = 1'b1;
                        hold_done = 1'b1;
                    end
                    run_pass(side, full, 1'b1);
                end
            end
        end
        steady = 1'b0;

        // largest grid: a partial pass cut short by a size write, then two rows and a bit
        reg_write(REG_GRID_SIZE, 256);
        run_pass(256, 40, 1'b0);
        reg_write(REG_GRID_SIZE, 511);
        reg_write(REG_PHI, rand_phi());
        if (!hold_done)
        begin
            hold_go   = 1'b1;
            hold_done = 1'b1;
        end
        steady = 1'b1;
        run_pass(256, 2 * 256 + 8, 1'b1);
        steady = 1'b0;

        cell_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[heat_diffusion_stencil.f]
hw/rtl/hds_pkg.sv
hw/rtl/hds_cell_if.sv
hw/rtl/hds_result_if.sv
hw/rtl/hds_ram.sv
hw/rtl/heat_diffusion_stencil.sv
tb/hds_update_checker.sv
tb/tb_heat_diffusion_stencil.sv
